### hdl/rgb_hsl_adjust_macros.svh
// Assertion helpers used by the RTL
`ifndef RGB_HSL_ADJUST_MACROS_SVH
`define RGB_HSL_ADJUST_MACROS_SVH

// Same-cycle implication, disabled in reset
`define RHSL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define RHSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rhsl_pkg.sv
package rhsl_pkg;

    // Input item: one RGBA pixel
    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } pixel_in_t;

    // Result item: adjusted RGBA pixel
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } pixel_out_t;

    // Config port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HUE_SHIFT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAT_OFFSET = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_GAIN = 2'd2;

    localparam logic [10:0] LIGHT_GAIN_RESET = 11'd256;

endpackage

### hdl/rhsl_div.sv
module rhsl_div #(
    parameter int W  = 9,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [W-1:0]  num,
    input  logic [W-1:0]  den,
    output logic [QW-1:0] quo
);
    // Restoring divider, one quotient bit per stage, MSB first.
    // Requires num < 2*den; remainder stays below 2*den between steps.
    logic [W-1:0]  rem_reg [QW];
    logic [W-1:0]  den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    logic [W-1:0]  rem_in  [QW];
    logic [W-1:0]  den_in  [QW];
    logic [QW-1:0] quo_in  [QW];
    logic [W-1:0]  rem_nx  [QW];
    logic [QW-1:0] ge;

    // Compare and subtract per stage
    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = num;
                den_in[k] = den;
                quo_in[k] = '0;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1];
                den_in[k] = den_reg[k-1];
                quo_in[k] = quo_reg[k-1];
            end
            ge[k]     = (rem_in[k] >= den_in[k]);
            rem_nx[k] = ge[k] ? (rem_in[k] - den_in[k]) : rem_in[k];
        end
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k] <= {rem_nx[k][W-2:0], 1'b0};
                den_reg[k] <= den_in[k];
                quo_reg[k] <= {quo_in[k][QW-2:0], ge[k]};
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

### hdl/rgb_hsl_adjust.sv
// HSL adjust of an RGBA pixel stream.
// Input channel: in_valid/in_ready with in_data (red, green, blue, alpha).
// Output channel: out_valid/out_ready with out_data; alpha is copied through.
// Config: cfg_we/cfg_index/cfg_data, write-only with no read-back;
//   index 0 hue shift (degrees), 1 saturation offset (1/256), 2 lightness
//   gain (1/256). Write only while no item is in flight.
// Throughput: one item per clock while the pipeline is not stalled (see Stall).
//   The item passes 4 front stages (capture, min/max, hue terms, hue wrap),
//   the FRAC_BITS + 1 stage pipelined dividers for saturation and hue
//   (lightness uses a reciprocal multiply delayed to match), 8 back stages
//   (clamps, multipliers, channel reconstruction) and the output register.
// Reset clears all valid bits and loads the registers with shift 0,
//   offset 0, gain 256.
// Stall: the pipeline shifts as one; it keeps taking items while its last
//   stage is empty or the output register can load, so one finished item
//   waiting at the output does not block the input until the pipe fills.
`include "rgb_hsl_adjust_macros.svh"

module rgb_hsl_adjust #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rhsl_pkg::pixel_in_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rhsl_pkg::pixel_out_t                out_data,
    input  logic                                cfg_we,
    input  logic [rhsl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rhsl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rhsl_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int QW  = F + 1;
    localparam int NST = F + 13;

    localparam logic [F:0]   ONE_FX  = {1'b1, {F{1'b0}}};
    localparam logic [F:0]   HALF_FX = ONE_FX >> 1;
    localparam logic [F:0]   THIRD_W = ONE_FX / 3;
    localparam logic [F-1:0] THIRD   = THIRD_W[F-1:0];
    localparam logic [F:0]   COMP_W  = ONE_FX - THIRD_W;

    localparam logic signed [10:0] DEG_TURN_S = 11'sd360;
    localparam logic [16:0]        DEG_TURN   = 17'd360;
    localparam logic signed [17:0] DEG_SECTOR = 18'sd60;

    // Reciprocal of 510 scaled by 2^(F+LSH), rounded up; exact for sum <= 510
    localparam int             LSH     = 18;
    localparam logic [F+9:0]   L_RECIP = (F+10)'(((64'd1 << (F + LSH)) / 64'd510) + 64'd1);

    // ---------------- configuration registers ----------------
    logic signed [9:0] hue_shift_reg;
    logic signed [9:0] sat_offset_reg;
    logic [10:0]       light_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_shift_reg  <= '0;
            sat_offset_reg <= '0;
            light_gain_reg <= LIGHT_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HUE_SHIFT:  hue_shift_reg  <= signed'(cfg_data[9:0]);
                CFG_SAT_OFFSET: sat_offset_reg <= signed'(cfg_data[9:0]);
                CFG_LIGHT_GAIN: light_gain_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Hue shift folded into 0..359 degrees
    logic signed [10:0] sh_ext;
    logic signed [10:0] sh_a;
    logic signed [10:0] sh_b;
    logic [8:0]         shift_mod;

    always_comb
    begin
        sh_ext = 11'(hue_shift_reg);
        if (sh_ext < 11'sd0)
            sh_a = sh_ext + DEG_TURN_S;
        else if (sh_ext >= DEG_TURN_S)
            sh_a = sh_ext - DEG_TURN_S;
        else
            sh_a = sh_ext;
        sh_b      = (sh_a < 11'sd0) ? (sh_a + DEG_TURN_S) : sh_a;
        shift_mod = sh_b[8:0];
    end

    // ---------------- flow control ----------------
    logic [NST-1:0] v_reg;
    logic           out_valid_reg;
    logic           en;

    assign en       = !v_reg[NST-1] || !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NST-2:0], in_valid};
    end

    // Alpha rides alongside
    logic [7:0] alpha_reg [NST];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_reg[0] <= in_data.in_alpha;
            for (int i = 1; i < NST; i++)
                alpha_reg[i] <= alpha_reg[i-1];
        end
    end

    // ---------------- stage A: capture ----------------
    logic [7:0] ra_reg, ga_reg, ba_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ra_reg <= in_data.in_red;
            ga_reg <= in_data.in_green;
            ba_reg <= in_data.in_blue;
        end
    end

    // ---------------- stage B: min/max, delta, sector ----------------
    logic               rmax, gmax, gray;
    logic [7:0]         mx, mn, delta;
    logic [8:0]         sum, sum_rev;
    logic signed [11:0] r12, g12, b12, d12, pre;
    logic [7:0]         sd, den_h;

    always_comb
    begin
        rmax = (ra_reg >= ga_reg) && (ra_reg >= ba_reg);
        gmax = !rmax && (ga_reg >= ba_reg);
        mx   = rmax ? ra_reg : (gmax ? ga_reg : ba_reg);
        if ((ra_reg <= ga_reg) && (ra_reg <= ba_reg))
            mn = ra_reg;
        else
            mn = (ga_reg <= ba_reg) ? ga_reg : ba_reg;
        delta   = mx - mn;
        sum     = {1'b0, mx} + {1'b0, mn};
        sum_rev = 9'd510 - sum;
        gray    = (delta == 8'd0);
        r12     = signed'({4'b0, ra_reg});
        g12     = signed'({4'b0, ga_reg});
        b12     = signed'({4'b0, ba_reg});
        d12     = signed'({4'b0, delta});
        if (rmax)
            pre = g12 - b12;
        else if (gmax)
            pre = (d12 <<< 1) + b12 - r12;
        else
            pre = (d12 <<< 2) + r12 - g12;
        if (gray)
            sd = 8'd1;
        else
            sd = (sum < 9'd255) ? sum[7:0] : sum_rev[7:0];
        den_h = gray ? 8'd1 : delta;
    end

    logic [8:0]         sumb_reg;
    logic [7:0]         deltab_reg, sdb_reg, denhb_reg;
    logic signed [11:0] preb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sumb_reg   <= sum;
            deltab_reg <= delta;
            sdb_reg    <= sd;
            denhb_reg  <= den_h;
            preb_reg   <= pre;
        end
    end

    // ---------------- stage C: hue terms in 1/(360*den) turns ----------------
    logic signed [17:0] basec_reg;
    logic [16:0]        hmulc_reg, fullc_reg;
    logic [8:0]         sumc_reg;
    logic [7:0]         deltac_reg, sdc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            basec_reg  <= 18'(preb_reg) * DEG_SECTOR;
            hmulc_reg  <= 17'(shift_mod) * 17'(denhb_reg);
            fullc_reg  <= 17'(denhb_reg) * DEG_TURN;
            sumc_reg   <= sumb_reg;
            deltac_reg <= deltab_reg;
            sdc_reg    <= sdb_reg;
        end
    end

    // ---------------- stage D: hue wrap ----------------
    logic signed [18:0] hn, full_s, hn_w;

    always_comb
    begin
        hn     = 19'(basec_reg) + signed'({2'b0, hmulc_reg});
        full_s = signed'({2'b0, fullc_reg});
        if (hn < 19'sd0)
            hn_w = hn + full_s;
        else if (hn >= full_s)
            hn_w = hn - full_s;
        else
            hn_w = hn;
    end

    logic [16:0] hund_reg, fulld_reg;
    logic [8:0]  sumd_reg;
    logic [7:0]  deltad_reg, sdd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hund_reg   <= hn_w[16:0];
            fulld_reg  <= fullc_reg;
            sumd_reg   <= sumc_reg;
            deltad_reg <= deltac_reg;
            sdd_reg    <= sdc_reg;
        end
    end

    // ---------------- dividers ----------------
    logic [QW-1:0] sq, lq, hq;

    rhsl_div #(.W(9), .QW(QW)) u_div_sat (
        .clk (clk),
        .en  (en),
        .num ({1'b0, deltad_reg}),
        .den ({1'b0, sdd_reg}),
        .quo (sq)
    );

    rhsl_div #(.W(18), .QW(QW)) u_div_hue (
        .clk (clk),
        .en  (en),
        .num ({1'b0, hund_reg}),
        .den ({1'b0, fulld_reg}),
        .quo (hq)
    );

    // Lightness sum/510 by reciprocal multiply, delayed to line up with the dividers
    logic [F+LSH:0] lmul;
    logic [F:0]     lq_reg [QW];

    assign lmul = (F+LSH+1)'(sumd_reg) * (F+LSH+1)'(L_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lq_reg[0] <= lmul[F+LSH:LSH];
            for (int i = 1; i < QW; i++)
                lq_reg[i] <= lq_reg[i-1];
        end
    end

    assign lq = lq_reg[QW-1];

    // ---------------- E1: saturation offset, lightness gain ----------------
    logic signed [F+2:0] off_sh, s_sum;
    logic [F:0]          s1;

    always_comb
    begin
        off_sh = (F+3)'(sat_offset_reg) <<< (F - 8);
        s_sum  = signed'({2'b0, sq}) + off_sh;
        if (s_sum < 0)
            s1 = '0;
        else if (s_sum > signed'({2'b0, ONE_FX}))
            s1 = ONE_FX;
        else
            s1 = s_sum[F:0];
    end

    logic [F:0]    s1_reg;
    logic [F+11:0] lp1_reg;
    logic [F-1:0]  h1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1;
            lp1_reg <= (F+12)'(lq) * (F+12)'(light_gain_reg);
            h1_reg  <= hq[F-1:0];
        end
    end

    // ---------------- E2: lightness clamp ----------------
    logic [F+3:0] lsh;
    logic [F:0]   l2;

    always_comb
    begin
        lsh = lp1_reg[F+11:8];
        l2  = (lsh > {3'b0, ONE_FX}) ? ONE_FX : lsh[F:0];
    end

    logic [F:0]   l2_reg, s2_reg;
    logic [F-1:0] h2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2_reg <= l2;
            s2_reg <= s1_reg;
            h2_reg <= h1_reg;
        end
    end

    // ---------------- E3: L*S product ----------------
    logic [2*F+1:0] ls_full;
    logic [F+1:0]   prod3_reg;
    logic [F:0]     l3_reg, s3_reg;
    logic [F-1:0]   h3_reg;

    assign ls_full = (2*F+2)'(l2_reg) * (2*F+2)'(s2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod3_reg <= ls_full[2*F+1:F];
            l3_reg    <= l2_reg;
            s3_reg    <= s2_reg;
            h3_reg    <= h2_reg;
        end
    end

    // ---------------- E4: v1/v2 and channel phases ----------------
    logic signed [F+3:0] l_s, s_s, p_s, v2, v1, v1c, v2c;
    logic [F:0]          tr_sum, tb_sum;
    logic [F-1:0]        tr, tb;

    always_comb
    begin
        l_s = signed'({3'b0, l3_reg});
        s_s = signed'({3'b0, s3_reg});
        p_s = signed'({2'b0, prod3_reg});
        if (l3_reg < HALF_FX)
            v2 = l_s + p_s;
        else
            v2 = l_s + s_s - p_s;
        v1  = (l_s <<< 1) - v2;
        v1c = (v1 < 0) ? '0 : v1;
        v2c = (v2 < v1c) ? v1c : v2;

        tr_sum = {1'b0, h3_reg} + THIRD_W;
        tr     = (tr_sum >= ONE_FX) ? tr_sum[F-1:0] : tr_sum[F-1:0];
        tb_sum = {1'b0, h3_reg} + COMP_W;
        tb     = (h3_reg >= THIRD) ? (h3_reg - THIRD) : tb_sum[F-1:0];
    end

    logic [F+1:0] v1_4_reg, v2_4_reg;
    logic [F-1:0] t4_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_4_reg  <= v1c[F+1:0];
            v2_4_reg  <= v2c[F+1:0];
            t4_reg[0] <= tr;
            t4_reg[1] <= h3_reg;
            t4_reg[2] <= tb;
        end
    end

    // ---------------- E5: ramp factor per channel ----------------
    logic [F+2:0] t6  [3];
    logic [F+1:0] t3  [3];
    logic [F+1:0] dn  [3];
    logic [F:0]   f5  [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            t6[c] = (F+3)'(t4_reg[c]) * (F+3)'(6);
            t3[c] = (F+2)'(t4_reg[c]) * (F+2)'(3);
            dn[c] = {ONE_FX, 1'b0} - t3[c];
            if (t6[c] < (F+3)'(ONE_FX))
                f5[c] = t6[c][F:0];
            else if ({t4_reg[c], 1'b0} < ONE_FX)
                f5[c] = ONE_FX;
            else if (t3[c] < {ONE_FX, 1'b0})
                f5[c] = {dn[c][F-1:0], 1'b0};
            else
                f5[c] = '0;
        end
    end

    logic [F+1:0] span5_reg, v1_5_reg;
    logic [F:0]   f5_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            span5_reg <= v2_4_reg - v1_4_reg;
            v1_5_reg  <= v1_4_reg;
            for (int c = 0; c < 3; c++)
                f5_reg[c] <= f5[c];
        end
    end

    // ---------------- E6: span * factor ----------------
    logic [2*F+2:0] m6_reg [3];
    logic [F+1:0]   v1_6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_6_reg <= v1_5_reg;
            for (int c = 0; c < 3; c++)
                m6_reg[c] <= (2*F+3)'(span5_reg) * (2*F+3)'(f5_reg[c]);
        end
    end

    // ---------------- E7: channel value ----------------
    logic [F+2:0] val7_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
                val7_reg[c] <= (F+3)'(v1_6_reg) + m6_reg[c][2*F+2:F];
        end
    end

    // ---------------- E8: scale to 8 bits ----------------
    logic [F+10:0] x255 [3];
    logic [10:0]   xb   [3];
    logic [7:0]    byte8 [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            x255[c]  = {val7_reg[c], 8'b0} - (F+11)'(val7_reg[c]);
            xb[c]    = x255[c][F+10:F];
            byte8[c] = (xb[c] > 11'd255) ? 8'hFF : xb[c][7:0];
        end
    end

    logic [7:0] byte8_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
                byte8_reg[c] <= byte8[c];
        end
    end

    // ---------------- output register ----------------
    pixel_out_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ready)
            out_valid_reg <= v_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg.out_red   <= byte8_reg[0];
            out_data_reg.out_green <= byte8_reg[1];
            out_data_reg.out_blue  <= byte8_reg[2];
            out_data_reg.out_alpha <= alpha_reg[NST-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- checks ----------------
    `RHSL_ASSERT_IMP(a_stall_gate, clk, rst_n, out_valid_reg && !out_ready, in_ready == !v_reg[NST-1], "pipe advanced into a stalled output")
    `RHSL_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, v_reg[0], "accepted item missing from first stage")
    `RHSL_ASSERT_NEXT(a_last_loads_out, clk, rst_n, v_reg[NST-1] && (!out_valid_reg || out_ready), out_valid_reg, "finished item not loaded to output")

endmodule

### tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rhsl_pkg::*;

    localparam int FRAC = 16;
    localparam longint ONE = 64'd1 << FRAC;
    localparam int PIPE_LAT = FRAC + 14;
    localparam longint CYCLE_LIMIT = 400000;
    // Index past the register list, must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    pixel_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    pixel_out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    rgb_hsl_adjust #(.FRAC_BITS(FRAC)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Predictor copy of the adjust registers
    longint hue_deg = 0;
    longint sat_off = 0;
    longint light_gain = 256;

    pixel_in_t  pixel_queue[$];
    pixel_out_t expected_pixels[$];
    int  errors = 0;
    int  sent = 0;
    int  received = 0;
    longint cycles = 0;
    bit  hold_input = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;

    function automatic longint channel_level(longint v1, longint v2, longint t);
        longint span;
        begin
            span = v2 - v1;
            if (6 * t < ONE) return v1 + ((span * 6 * t) >> FRAC);
            if (2 * t < ONE) return v2;
            if (3 * t < 2 * ONE) return v1 + ((span * 2 * (2 * ONE - 3 * t)) >> FRAC);
            return v1;
        end
    endfunction

    function automatic logic [7:0] level_to_byte(longint v);
        longint c;
        begin
            c = (255 * v) >> FRAC;
            return (c > 255) ? 8'd255 : c[7:0];
        end
    endfunction

    // Expected adjusted pixel for one input pixel
    function automatic pixel_out_t adjust_pixel(pixel_in_t px);
        longint r, g, b, mx, mn, dl, sm, den, hnum, full, s, l, v1, v2, h, prod;
        longint third, tr, tb;
        pixel_out_t res;
        begin
            r = px.in_red; g = px.in_green; b = px.in_blue;
            third = ONE / 3;
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            dl = mx - mn;
            sm = mx + mn;
            l = (sm * ONE) / 510;
            if (dl == 0)
            begin
                s = 0; hnum = 0; den = 1;
            end
            else
            begin
                s = (dl * ONE) / ((sm < 255) ? sm : (510 - sm));
                if (r == mx) hnum = g - b;
                else if (g == mx) hnum = 2 * dl + b - r;
                else hnum = 4 * dl + r - g;
                den = dl;
            end
            full = 360 * den;
            hnum = (hnum * 60 + hue_deg * den) % full;
            if (hnum < 0) hnum += full;
            h = (hnum * ONE) / full;
            s = s + sat_off * (ONE >> 8);
            if (s > ONE) s = ONE;
            if (s < 0) s = 0;
            l = (l * light_gain) >> 8;
            if (l > ONE) l = ONE;
            if (s == 0)
            begin
                res.out_red = level_to_byte(l);
                res.out_green = res.out_red;
                res.out_blue = res.out_red;
            end
            else
            begin
                prod = (l * s) >> FRAC;
                v2 = (l < ONE / 2) ? l + prod : l + s - prod;
                v1 = 2 * l - v2;
                if (v1 < 0) v1 = 0;
                if (v2 < v1) v2 = v1;
                tr = h + third;
                if (tr >= ONE) tr -= ONE;
                tb = (h >= third) ? h - third : h + ONE - third;
                res.out_red = level_to_byte(channel_level(v1, v2, tr));
                res.out_green = level_to_byte(channel_level(v1, v2, h));
                res.out_blue = level_to_byte(channel_level(v1, v2, tb));
            end
            res.out_alpha = px.in_alpha;
            return res;
        end
    endfunction

    // Driver: presents queued pixels with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_pixels.push_back(adjust_pixel(in_data));
                sent <= sent + 1;
                in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
                if ($urandom_range(0, 3) == 0) in_gap = 0;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pixel_queue.size() > 0 && !hold_input)
                begin
                    in_valid <= 1'b1;
                    in_data <= pixel_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure and result check
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                received <= received + 1;
                if (expected_pixels.size() == 0)
                begin
                    errors <= errors + 1;
                    $display("%0t unexpected pixel expected=none actual=%h", $realtime,
                             out_data);
                end
                else if (expected_pixels[0] !== out_data)
                begin
                    errors <= errors + 1;
                    $display("%0t pixel mismatch expected=%h actual=%h", $realtime,
                             expected_pixels[0], out_data);
                    void'(expected_pixels.pop_front());
                end
                else
                    void'(expected_pixels.pop_front());
                out_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            end
            if (out_gap > 0)
            begin
                out_gap = out_gap - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        begin
            while (pixel_queue.size() > 0 || in_valid || expected_pixels.size() > 0)
                @(posedge clk);
            repeat (PIPE_LAT + 4) @(posedge clk);
        end
    endtask

    // Register write while idle; predictor updated alongside
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        begin
            wait_drained();
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            case (idx)
                CFG_HUE_SHIFT: hue_deg = val[9] ? longint'(val[9:0]) - 1024 : longint'(val[9:0]);
                CFG_SAT_OFFSET: sat_off = val[9] ? longint'(val[9:0]) - 1024 : longint'(val[9:0]);
                CFG_LIGHT_GAIN: light_gain = val;
                default: ;
            endcase
        end
    endtask

    function automatic pixel_in_t rand_pixel();
        pixel_in_t p;
        begin
            p = $urandom;
            case ($urandom_range(0, 5))
                0: begin p.in_green = p.in_red; p.in_blue = p.in_red; end
                1: p.in_green = p.in_red;
                2: p.in_blue = p.in_green;
                default: ;
            endcase
            return p;
        end
    endfunction

    task automatic queue_random(int n);
        begin
            repeat (n) pixel_queue.push_back(rand_pixel());
        end
    endtask

    task automatic queue_directed();
        begin
            pixel_queue.push_back('{8'd0, 8'd0, 8'd0, 8'd0});
            pixel_queue.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
            pixel_queue.push_back('{8'd128, 8'd128, 8'd128, 8'h5a});
            pixel_queue.push_back('{8'd255, 8'd0, 8'd0, 8'ha5});
            pixel_queue.push_back('{8'd0, 8'd255, 8'd0, 8'd1});
            pixel_queue.push_back('{8'd0, 8'd0, 8'd255, 8'd128});
            pixel_queue.push_back('{8'd255, 8'd255, 8'd0, 8'd7});
            pixel_queue.push_back('{8'd0, 8'd255, 8'd255, 8'd9});
            pixel_queue.push_back('{8'd255, 8'd0, 8'd255, 8'd3});
            pixel_queue.push_back('{8'd200, 8'd100, 8'd50, 8'd77});
            pixel_queue.push_back('{8'd1, 8'd0, 8'd0, 8'd0});
            pixel_queue.push_back('{8'd254, 8'd255, 8'd255, 8'd0});
        end
    endtask

    // Settings: hue shift, saturation offset, lightness gain
    int hue_set[8] = '{0, 360, -360, 511, -512, 90, -45, 180};
    int sat_set[8] = '{0, 256, -256, 511, -512, 64, -100, 30};
    int gain_set[8] = '{256, 0, 1024, 2047, 128, 512, 300, 1};

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings first
        queue_directed();
        queue_random(60);
        for (int k = 0; k < 8; k++)
        begin
            write_reg(CFG_HUE_SHIFT, hue_set[k][CFG_DATA_W-1:0]);
            write_reg(CFG_SAT_OFFSET, sat_set[k][CFG_DATA_W-1:0]);
            write_reg(CFG_LIGHT_GAIN, gain_set[k][CFG_DATA_W-1:0]);
            // Index past the register list must be ignored
            write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
            if (k == 1) queue_directed();
            queue_random(60);
            if (k == 3)
            begin
                // Sender holds off until the pipe empties
                hold_input = 1'b1;
                while (expected_pixels.size() > 0 || in_valid) @(posedge clk);
                hold_input = 1'b0;
            end
        end
        // Random settings phases
        for (int k = 0; k < 5; k++)
        begin
            write_reg(CFG_HUE_SHIFT, CFG_DATA_W'($urandom));
            write_reg(CFG_SAT_OFFSET, CFG_DATA_W'($urandom));
            write_reg(CFG_LIGHT_GAIN, CFG_DATA_W'($urandom_range(0, 1100)));
            queue_random(100);
        end
        wait_drained();

        $display("Covered %0d pixels in, %0d out across 14 register settings.",
                 sent, received);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire
